/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. They expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define GQA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define GQA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/gqa_pkg.sv */
// ----------------------------------------------------------------------------
// gqa_pkg
// Shared sizes, codes and tables of the attention engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gqa_pkg;

	localparam int HEAD_DIM     = 64;
	localparam int MAX_POS      = 256;
	localparam int MAX_KV_HEADS = 8;
	localparam int MAX_Q_HEADS  = 16;

	localparam int DIM_W  = $clog2(HEAD_DIM);
	localparam int POS_W  = $clog2(MAX_POS);
	localparam int GRP_W  = (MAX_KV_HEADS > 1) ? $clog2(MAX_KV_HEADS) : 1;
	localparam int ADDR_W = POS_W + GRP_W + DIM_W;

	// item field widths
	localparam int CMD_W      = 2;
	localparam int POSITION_W = 8;
	localparam int KV_GROUP_W = 3;
	localparam int HEAD_W     = 4;
	localparam int DIMIDX_W   = 6;
	localparam int DATA_W     = 16;
	localparam int LENGTH_W   = 9;

	// config port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int QH_W       = 5;
	localparam int KH_W       = 4;
	localparam int SCALE_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_HEADS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KV_HEADS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_SCALE = 2'd2;

	localparam logic [QH_W-1:0]    QH_RESET    = 5'd16;
	localparam logic [KH_W-1:0]    KH_RESET    = 4'd8;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd5793;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_KEY   = 2'd0,
		CMD_WRITE_VALUE = 2'd1,
		CMD_WRITE_QUERY = 2'd2,
		CMD_RUN         = 2'd3
	} cmd_t;

	// arithmetic widths
	localparam int DOT_W   = 2 * DATA_W + DIM_W + 1;
	localparam int SCORE_W = 32;
	localparam int ACC_W   = 48;
	localparam int WGT_W   = 16;
	localparam int SUM_W   = WGT_W + POS_W + 1;
	localparam int NUM_W   = ACC_W + 2;
	localparam int DEN_W   = SUM_W + 1;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// 2^(-i/16) in Q1.16
	function automatic logic [16:0] pow_tab(input logic [4:0] idx);
		logic [16:0] t;
		case (idx)
			5'd0:    t = 17'd65536;
			5'd1:    t = 17'd62757;
			5'd2:    t = 17'd60097;
			5'd3:    t = 17'd57549;
			5'd4:    t = 17'd55109;
			5'd5:    t = 17'd52773;
			5'd6:    t = 17'd50535;
			5'd7:    t = 17'd48393;
			5'd8:    t = 17'd46341;
			5'd9:    t = 17'd44376;
			5'd10:   t = 17'd42495;
			5'd11:   t = 17'd40693;
			5'd12:   t = 17'd38968;
			5'd13:   t = 17'd37316;
			5'd14:   t = 17'd35734;
			5'd15:   t = 17'd34219;
			5'd16:   t = 17'd32768;
			default: t = 17'd32768;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

/* src/gqa_if.sv */
// ----------------------------------------------------------------------------
// gqa_if
// Request and result channels of the attention engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gqa_req_if;
	logic                            valid;
	logic                            ready;
	logic [gqa_pkg::CMD_W-1:0]       cmd;
	logic [gqa_pkg::POSITION_W-1:0]  position;
	logic [gqa_pkg::KV_GROUP_W-1:0]  kv_group;
	logic [gqa_pkg::HEAD_W-1:0]      query_head;
	logic [gqa_pkg::DIMIDX_W-1:0]    dim_index;
	logic signed [gqa_pkg::DATA_W-1:0] value;
	logic [gqa_pkg::LENGTH_W-1:0]    length;

	modport source (output valid, cmd, position, kv_group, query_head, dim_index, value, length,
		input ready);
	modport sink (input valid, cmd, position, kv_group, query_head, dim_index, value, length,
		output ready);
endinterface

interface gqa_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [gqa_pkg::DIMIDX_W-1:0]      out_index;
	logic signed [gqa_pkg::DATA_W-1:0] out_value;
	logic                              last;
	logic                              error;

	modport source (output valid, out_index, out_value, last, error, input ready);
	modport sink (input valid, out_index, out_value, last, error, output ready);
endinterface

`default_nettype wire

/* src/gqa_ram.sv */
// ----------------------------------------------------------------------------
// gqa_ram
// Simple dual-port RAM, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/gqa_div.sv */
// ----------------------------------------------------------------------------
// gqa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqa_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [gqa_pkg::NUM_W-1:0]   num,
	input  wire logic [gqa_pkg::DEN_W-1:0]   den,
	output      gqa_pkg::div_status_t        status,
	output      logic [gqa_pkg::NUM_W-1:0]   quo
);

	localparam int CNT_W = $clog2(gqa_pkg::NUM_W + 1);

	logic [gqa_pkg::DEN_W-1:0] rem_q;
	logic [gqa_pkg::DEN_W-1:0] den_q;
	logic [gqa_pkg::NUM_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      done_q;
	logic [gqa_pkg::DEN_W:0]   trial;
	logic                      fits;

	assign trial = {rem_q, quo_q[gqa_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(gqa_pkg::NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? gqa_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[gqa_pkg::DEN_W-1:0];
			quo_q <= {quo_q[gqa_pkg::NUM_W-2:0], fits};
		end
	end

	assign status.busy = cnt_q != '0;
	assign status.done = done_q;
	assign quo         = quo_q;

endmodule

`default_nettype wire

/* src/grouped_query_attention_engine_core.sv */
// ----------------------------------------------------------------------------
// grouped_query_attention_engine_core
// Single-head decode attention over a key/value cache with grouped heads.
// ----------------------------------------------------------------------------
// Key, value and query writes are taken one item per cycle while idle with
// the output register free, and produce no result. A run item (query head,
// length L) first derives its key/value group with a subtract loop, then
// makes three passes over on-chip RAMs: a score pass (one query/key product
// per cycle off the cache read port), a weight pass (one read-modify-write of
// an output accumulator per cycle), and an output pass in which the
// bit-serial divider normalizes each accumulator. Ready stays low during a
// run. A length of 0 or above MAX_POS returns one error item at once. Caches
// and the query vector hold nothing until written; accumulators are cleared
// by the first position of each run, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module grouped_query_attention_engine_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	gqa_req_if.sink                                req,
	gqa_rsp_if.source                              rsp,
	input  wire logic                              cfg_we,
	input  wire logic [gqa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gqa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int POS_W  = gqa_pkg::POS_W;
	localparam int DIM_W  = gqa_pkg::DIM_W;
	localparam int GRP_W  = gqa_pkg::GRP_W;
	localparam int ADDR_W = gqa_pkg::ADDR_W;
	localparam int DOT_W  = gqa_pkg::DOT_W;
	localparam int HI_W   = DOT_W - 19 + 17;
	localparam int LO_W   = 19 + 16;
	localparam int PROD_W = DOT_W + 17;
	localparam int EP_W   = 49;
	localparam int E_W    = 33;
	localparam int ACC_W  = gqa_pkg::ACC_W;
	localparam int SUM_W  = gqa_pkg::SUM_W;
	localparam int NUM_W  = gqa_pkg::NUM_W;
	localparam int DEN_W  = gqa_pkg::DEN_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GROUP, ST_DOT, ST_DOT_DRAIN, ST_SC1, ST_SC2,
		ST_WRD, ST_WE1, ST_WE2, ST_WE3, ST_VAL, ST_VAL_DRAIN,
		ST_ORD, ST_OLD, ST_DIV, ST_EMIT
	} state_t;

	// ---------------- configuration registers ----------------
	logic [gqa_pkg::QH_W-1:0]    qh_q;
	logic [gqa_pkg::KH_W-1:0]    kh_q;
	logic [gqa_pkg::SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qh_q    <= gqa_pkg::QH_RESET;
			kh_q    <= gqa_pkg::KH_RESET;
			scale_q <= gqa_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gqa_pkg::CFG_QUERY_HEADS: qh_q    <= cfg_data[gqa_pkg::QH_W-1:0];
				gqa_pkg::CFG_KV_HEADS:    kh_q    <= cfg_data[gqa_pkg::KH_W-1:0];
				gqa_pkg::CFG_SCORE_SCALE: scale_q <= cfg_data[gqa_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped head counts
	logic [gqa_pkg::QH_W-1:0] qh_c;
	logic [gqa_pkg::KH_W-1:0] kh_c;
	assign qh_c = (qh_q == '0) ? gqa_pkg::QH_W'(1) :
		(32'(qh_q) > gqa_pkg::MAX_Q_HEADS) ? gqa_pkg::QH_W'(gqa_pkg::MAX_Q_HEADS) : qh_q;
	assign kh_c = (kh_q == '0) ? gqa_pkg::KH_W'(1) :
		(32'(kh_q) > gqa_pkg::MAX_KV_HEADS) ? gqa_pkg::KH_W'(gqa_pkg::MAX_KV_HEADS) : kh_q;

	// ---------------- control state ----------------
	state_t            state_q;
	logic [POS_W-1:0]  p_q;
	logic [POS_W-1:0]  last_pos_q;
	logic [DIM_W-1:0]  d_q;
	logic [GRP_W-1:0]  g_q;
	logic [7:0]        gnum_q;
	logic [7:0]        gquo_q;
	logic signed [gqa_pkg::SCORE_W-1:0] mx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [gqa_pkg::WGT_W-1:0] w_q;
	logic [EP_W-1:0]   eprod_q;
	logic [E_W-1:0]    e_q;
	logic signed [HI_W-1:0] hi_q;
	logic [LO_W-1:0]   lo_q;
	logic              neg_q;

	logic                              out_valid_q;
	logic [DIM_W-1:0]                  out_index_q;
	logic signed [gqa_pkg::DATA_W-1:0] out_value_q;
	logic                              out_last_q;
	logic                              out_error_q;

	// ---------------- request decode ----------------
	logic req_fire, in_range, bad_len, out_free;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign in_range  = (32'(req.position) < gqa_pkg::MAX_POS) &&
		(32'(req.kv_group) < gqa_pkg::MAX_KV_HEADS) && (32'(req.dim_index) < gqa_pkg::HEAD_DIM);
	assign bad_len   = (req.length == '0) || (32'(req.length) > gqa_pkg::MAX_POS);

	logic [ADDR_W-1:0] cache_waddr, cache_raddr;
	assign cache_waddr = {POS_W'(req.position), GRP_W'(req.kv_group), DIM_W'(req.dim_index)};
	assign cache_raddr = {p_q, g_q, d_q};

	logic key_we, val_we, qry_we;
	assign key_we = req_fire && (req.cmd == gqa_pkg::CMD_WRITE_KEY) && in_range;
	assign val_we = req_fire && (req.cmd == gqa_pkg::CMD_WRITE_VALUE) && in_range;
	assign qry_we = req_fire && (req.cmd == gqa_pkg::CMD_WRITE_QUERY) &&
		(32'(req.dim_index) < gqa_pkg::HEAD_DIM);

	// ---------------- memories ----------------
	logic [gqa_pkg::DATA_W-1:0] key_rd, val_rd, qry_rd;
	logic [gqa_pkg::SCORE_W-1:0] score_rd;
	logic [ACC_W-1:0] acc_rd;
	logic score_we, acc_we;
	logic signed [gqa_pkg::SCORE_W-1:0] score_new;
	logic [ACC_W-1:0] acc_wdata;
	logic [DIM_W-1:0] d_s1, d_s2;

	gqa_ram #(.DEPTH(2 ** ADDR_W), .WIDTH(gqa_pkg::DATA_W)) u_key_cache (
		.clk(clk), .we(key_we), .waddr(cache_waddr), .wdata(req.value),
		.raddr(cache_raddr), .rdata(key_rd));

	gqa_ram #(.DEPTH(2 ** ADDR_W), .WIDTH(gqa_pkg::DATA_W)) u_value_cache (
		.clk(clk), .we(val_we), .waddr(cache_waddr), .wdata(req.value),
		.raddr(cache_raddr), .rdata(val_rd));

	gqa_ram #(.DEPTH(gqa_pkg::HEAD_DIM), .WIDTH(gqa_pkg::DATA_W)) u_query (
		.clk(clk), .we(qry_we), .waddr(DIM_W'(req.dim_index)), .wdata(req.value),
		.raddr(d_q), .rdata(qry_rd));

	gqa_ram #(.DEPTH(gqa_pkg::MAX_POS), .WIDTH(gqa_pkg::SCORE_W)) u_score (
		.clk(clk), .we(score_we), .waddr(p_q), .wdata(score_new),
		.raddr(p_q), .rdata(score_rd));

	// accumulators: read at issue, written back from stage s2 at a different element
	gqa_ram #(.DEPTH(gqa_pkg::HEAD_DIM), .WIDTH(ACC_W)) u_acc (
		.clk(clk), .we(acc_we), .waddr(d_s2), .wdata(acc_wdata),
		.raddr(d_q), .rdata(acc_rd));

	// ---------------- product pipeline ----------------
	// s1: RAM data back; s2: product registered; then accumulate or write back
	logic issue, v1_q, v2_q, val_s1, val_s2;
	logic signed [DOT_W-1:0] dot_q;
	logic signed [2*gqa_pkg::DATA_W-1:0] qk_s2;
	logic signed [gqa_pkg::DATA_W+gqa_pkg::WGT_W:0] wv_s2;
	logic [ACC_W-1:0] accold_s2;
	logic dot_clear;

	assign issue = (state_q == ST_DOT) || (state_q == ST_VAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			v1_q <= issue;
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		d_s1   <= d_q;
		d_s2   <= d_s1;
		val_s1 <= state_q == ST_VAL;
		val_s2 <= val_s1;
		qk_s2  <= $signed(qry_rd) * $signed(key_rd);
		wv_s2  <= $signed({1'b0, w_q}) * $signed(val_rd);
		// the first position of a run starts every accumulator from zero
		accold_s2 <= (p_q == '0) ? '0 : acc_rd;
		if (dot_clear) begin
			dot_q <= '0;
		end else if (v2_q && !val_s2) begin
			dot_q <= dot_q + DOT_W'(qk_s2);
		end
	end

	assign acc_we    = v2_q && val_s2;
	assign acc_wdata = accold_s2 + ACC_W'(wv_s2);

	// ---------------- score scaling ----------------
	logic signed [PROD_W-1:0] sc_full;
	assign sc_full = (PROD_W'(hi_q) <<< 19) + $signed(PROD_W'(lo_q)) +
		$signed(PROD_W'(1) << 26);
	assign score_new = gqa_pkg::SCORE_W'(sc_full >>> 27);
	assign score_we  = state_q == ST_SC2;

	// ---------------- weight ----------------
	logic signed [gqa_pkg::SCORE_W-1:0] diff;
	logic [E_W-12:0] e_n;
	logic [4:0]  e_i;
	logic [6:0]  e_r;
	logic [16:0] t0, t1, dt, m_val, w_sh;
	logic [23:0] corr;
	logic [gqa_pkg::WGT_W-1:0] w_new;

	assign diff  = mx_q - $signed(score_rd);
	assign e_n   = e_q[E_W-1:11];
	assign e_i   = {1'b0, e_q[10:7]};
	assign e_r   = e_q[6:0];
	assign t0    = gqa_pkg::pow_tab(e_i);
	assign t1    = gqa_pkg::pow_tab(e_i + 5'd1);
	assign dt    = t0 - t1;
	assign corr  = (24'(dt) * 24'(e_r) + 24'd64) >> 7;
	assign m_val = t0 - 17'(corr);
	assign w_sh  = m_val >> e_n[4:0];
	assign w_new = (32'(e_n) > 16) ? '0 :
		(w_sh > 17'd65535) ? gqa_pkg::WGT_W'(65535) : w_sh[gqa_pkg::WGT_W-1:0];

	// ---------------- normalization ----------------
	gqa_pkg::div_status_t div_st;
	logic [NUM_W-1:0] div_quo, div_num;
	logic [DEN_W-1:0] div_den;
	logic [ACC_W-1:0] acc_mag;
	logic div_start;

	assign acc_mag   = acc_rd[ACC_W-1] ? ACC_W'(-$signed(acc_rd)) : acc_rd;
	assign div_num   = NUM_W'({acc_mag, 1'b0}) + NUM_W'(sum_q);
	assign div_den   = {sum_q, 1'b0};
	assign div_start = state_q == ST_OLD;

	gqa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.status(div_st), .quo(div_quo));

	logic signed [gqa_pkg::DATA_W-1:0] q_sat;
	always_comb begin
		if (neg_q) begin
			q_sat = (div_quo > NUM_W'(32768)) ? gqa_pkg::DATA_W'(-32768) :
				-$signed(div_quo[gqa_pkg::DATA_W-1:0]);
		end else begin
			q_sat = (div_quo > NUM_W'(32767)) ? gqa_pkg::DATA_W'(32767) :
				$signed(div_quo[gqa_pkg::DATA_W-1:0]);
		end
	end

	logic emit_load, err_load, last_dim;
	assign last_dim  = d_q == DIM_W'(gqa_pkg::HEAD_DIM - 1);
	assign emit_load = (state_q == ST_EMIT) && out_free;
	// a bad run is only taken in idle with the output register free
	assign err_load  = req_fire && (req.cmd == gqa_pkg::CMD_RUN) && bad_len;
	assign dot_clear = (state_q == ST_IDLE) || (state_q == ST_SC2);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			p_q         <= '0;
			d_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load || err_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.cmd == gqa_pkg::CMD_RUN)) begin
						if (bad_len) begin
							out_index_q <= '0;
							out_value_q <= '0;
							out_last_q  <= 1'b1;
							out_error_q <= 1'b1;
						end else begin
							last_pos_q <= POS_W'(req.length - 1'b1);
							gnum_q     <= 8'(req.query_head) * 8'(kh_c);
							gquo_q     <= '0;
							p_q        <= '0;
							d_q        <= '0;
							sum_q      <= '0;
							state_q    <= ST_GROUP;
						end
					end
				end
				ST_GROUP: begin
					if (gnum_q >= 8'(qh_c)) begin
						gnum_q <= gnum_q - 8'(qh_c);
						gquo_q <= gquo_q + 8'd1;
					end else begin
						g_q     <= (gquo_q >= 8'(kh_c)) ? GRP_W'(kh_c - 1'b1) : GRP_W'(gquo_q);
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					d_q <= d_q + 1'b1;
					if (last_dim) begin
						d_q     <= '0;
						state_q <= ST_DOT_DRAIN;
					end
				end
				ST_DOT_DRAIN: begin
					if (!v1_q && !v2_q) begin
						state_q <= ST_SC1;
					end
				end
				ST_SC1: begin
					hi_q    <= $signed(dot_q[DOT_W-1:19]) * $signed({1'b0, scale_q});
					lo_q    <= dot_q[18:0] * scale_q;
					state_q <= ST_SC2;
				end
				ST_SC2: begin
					if ((p_q == '0) || (score_new > mx_q)) begin
						mx_q <= score_new;
					end
					if (p_q == last_pos_q) begin
						p_q     <= '0;
						state_q <= ST_WRD;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_DOT;
					end
				end
				ST_WRD: state_q <= ST_WE1;
				ST_WE1: begin
					eprod_q <= EP_W'($unsigned(diff)) * EP_W'(gqa_pkg::LOG2E_Q16);
					state_q <= ST_WE2;
				end
				ST_WE2: begin
					e_q     <= E_W'((eprod_q + EP_W'(32768)) >> 16);
					state_q <= ST_WE3;
				end
				ST_WE3: begin
					w_q     <= w_new;
					sum_q   <= sum_q + SUM_W'(w_new);
					state_q <= ST_VAL;
				end
				ST_VAL: begin
					d_q <= d_q + 1'b1;
					if (last_dim) begin
						d_q     <= '0;
						state_q <= ST_VAL_DRAIN;
					end
				end
				ST_VAL_DRAIN: begin
					if (!v1_q && !v2_q) begin
						if (p_q == last_pos_q) begin
							state_q <= ST_ORD;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= ST_WRD;
						end
					end
				end
				ST_ORD: state_q <= ST_OLD;
				ST_OLD: begin
					neg_q   <= acc_rd[ACC_W-1];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_index_q <= d_q;
						out_value_q <= q_sat;
						out_last_q  <= last_dim;
						out_error_q <= 1'b0;
						if (last_dim) begin
							d_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							d_q     <= d_q + 1'b1;
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_index = out_index_q;
	assign rsp.out_value = out_value_q;
	assign rsp.last      = out_last_q;
	assign rsp.error     = out_error_q;

	// ---------------- checks ----------------
	`GQA_ASSERT_IMP(a_ready_idle, req.ready, state_q == ST_IDLE, "ready outside idle")
	`GQA_ASSERT_IMP(a_acc_no_alias, acc_we && issue, d_s2 != d_q, "accumulator RMW overlap")
	`GQA_ASSERT_IMP(a_div_free, div_start, !div_st.busy, "divider restarted while busy")
	`GQA_ASSERT_NXT(a_last_ends, emit_load && last_dim, state_q == ST_IDLE, "run did not end")

endmodule

`default_nettype wire
